// ===== rtl/lbpc_pkg.sv =====
// Shared types and constants for the 3x3 local binary pattern block.
`timescale 1ns / 1ps
`default_nettype none
package lbpc_pkg;

    localparam int PIX_W          = 8;
    localparam int POS_W          = 6;
    localparam int PATCH_SIZE_DEF = 10;

    // Bit positions of the neighbours inside a code.
    localparam int BIT_LEFT      = 7;
    localparam int BIT_BOT_LEFT  = 6;
    localparam int BIT_BOT       = 5;
    localparam int BIT_BOT_RIGHT = 4;
    localparam int BIT_RIGHT     = 3;
    localparam int BIT_TOP_RIGHT = 2;
    localparam int BIT_TOP       = 1;
    localparam int BIT_TOP_LEFT  = 0;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [POS_W-1:0] t_pos;

    // Control that travels with a pixel from the read stage to the output.
    typedef struct packed {
        logic emit;
        logic last;
        t_pos position;
    } t_s1_ctl;

endpackage
`default_nettype wire

// ===== rtl/lbpc_line_mem.sv =====
// Line store memory holding the two previous rows, one column per entry.
`timescale 1ns / 1ps
`default_nettype none
module lbpc_line_mem
    import lbpc_pkg::*;
#(
    parameter int DEPTH = PATCH_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output logic      [2*PIX_W-1:0] o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire logic [2*PIX_W-1:0] i_wr_data
);

    logic [2*PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lbpc_window.sv =====
// Two stored window columns and the eight neighbour comparisons.
`timescale 1ns / 1ps
`default_nettype none
module lbpc_window
    import lbpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire t_pix i_top,
    input  wire t_pix i_mid,
    input  wire t_pix i_bot,
    output t_pix      o_code
);

    // Column 2 holds the centre column and column 1 the left one; the incoming column is the right one.
    t_pix r_c1_top, r_c1_mid, r_c1_bot;
    t_pix r_c2_top, r_c2_mid, r_c2_bot;
    t_pix w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_top <= '0;
            r_c1_mid <= '0;
            r_c1_bot <= '0;
            r_c2_top <= '0;
            r_c2_mid <= '0;
            r_c2_bot <= '0;
        end else if (i_shift) begin
            r_c1_top <= r_c2_top;
            r_c1_mid <= r_c2_mid;
            r_c1_bot <= r_c2_bot;
            r_c2_top <= i_top;
            r_c2_mid <= i_mid;
            r_c2_bot <= i_bot;
        end
    end

    // The code is formed from the stored columns before this shift and the incoming column.
    assign w_m = r_c2_mid;

    always_comb begin
        o_code                = '0;
        o_code[BIT_LEFT]      = r_c1_mid > w_m;
        o_code[BIT_BOT_LEFT]  = r_c1_bot > w_m;
        o_code[BIT_BOT]       = r_c2_bot > w_m;
        o_code[BIT_BOT_RIGHT] = i_bot > w_m;
        o_code[BIT_RIGHT]     = i_mid > w_m;
        o_code[BIT_TOP_RIGHT] = i_top > w_m;
        o_code[BIT_TOP]       = r_c2_top > w_m;
        o_code[BIT_TOP_LEFT]  = r_c1_top > w_m;
    end

endmodule
`default_nettype wire

// ===== rtl/lbp_patch_codes.sv =====
// Top level: counters, read stage, line store, window and output register.
//
//  Channel   Direction  Valid     Ready     Payload
//  input     in         i_valid   o_ready   i_pixel
//  output    out        o_valid   i_ready   o_code, o_position, o_patch_done
//
// One pixel is accepted every cycle while o_ready is high; its code passes the
// read stage and then the output register. The line store read at acceptance
// returns in the next cycle and is held until the read stage advances, when the
// window shifts, the code is formed and the column is written back. Reset clears
// counters, window and valid flags; the line store is not cleared. A held
// output beat stalls a read stage that carries a code, and the input with it.
`timescale 1ns / 1ps
`default_nettype none
module lbp_patch_codes
    import lbpc_pkg::*;
#(
    parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_pix i_pixel,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pix      o_code,
    output t_pos      o_position,
    output logic      o_patch_done
);

    localparam int            CW       = $clog2(PATCH_SIZE);
    localparam logic [CW-1:0] LAST_IDX = CW'(PATCH_SIZE - 1);
    localparam logic [CW-1:0] TWO      = CW'(2);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    t_pos          r_code_index, n_code_index;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_pix          r_s1_px;
    t_s1_ctl       r_s1_ctl;
    t_s1_ctl       w_ctl;

    logic               r_out_valid;
    logic               w_adv;
    logic               w_acc;
    logic [2*PIX_W-1:0] w_rd_data;
    t_pix               w_code;

    assign w_adv   = r_s1_valid && (!r_s1_ctl.emit || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || w_adv;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_ctl.emit     = (r_row >= TWO) && (r_col >= TWO);
        w_ctl.last     = (r_row == LAST_IDX) && (r_col == LAST_IDX);
        w_ctl.position = r_code_index;
        n_col          = r_col;
        n_row          = r_row;
        n_code_index   = r_code_index;
        if (w_acc) begin
            if (w_ctl.emit) begin
                n_code_index = r_code_index + 1'b1;
            end
            if (r_col == LAST_IDX) begin
                n_col = '0;
                if (r_row == LAST_IDX) begin
                    n_row        = '0;
                    n_code_index = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_code_index <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_code_index <= n_code_index;
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv && r_s1_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_col <= r_col;
            r_s1_px  <= i_pixel;
            r_s1_ctl <= w_ctl;
        end
        if (w_adv && r_s1_ctl.emit) begin
            o_code       <= w_code;
            o_position   <= r_s1_ctl.position;
            o_patch_done <= r_s1_ctl.last;
        end
    end

    assign o_valid = r_out_valid;

    lbpc_line_mem #(
        .DEPTH (PATCH_SIZE),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({w_rd_data[PIX_W-1:0], r_s1_px})
    );

    lbpc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_adv),
        .i_top   (w_rd_data[2*PIX_W-1:PIX_W]),
        .i_mid   (w_rd_data[PIX_W-1:0]),
        .i_bot   (r_s1_px),
        .o_code  (w_code)
    );

`ifndef ASSERT_OFF
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_patch_done) |-> (o_position == POS_W'((PATCH_SIZE - 2) * (PATCH_SIZE - 2) - 1)))
        else $error("patch end code carries a wrong position");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= LAST_IDX) && (r_row <= LAST_IDX))
        else $error("row or column counter beyond the patch");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_col) && $stable(w_rd_data)))
        else $error("stalled read stage lost its column or line data");

    a_border_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && ((r_row < TWO) || (r_col < TWO))) |-> !w_ctl.emit)
        else $error("border pixel marked to emit a code");
`endif

endmodule
`default_nettype wire
